FILE: rtl/core/first_fit_aligned_heap_allocator_defines.svh
// Assertion macros shared by the heap allocator RTL.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef FIRST_FIT_ALIGNED_HEAP_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_ALIGNED_HEAP_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define FFA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define FFA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/ffa_pkg.sv
// Types and constants of the first-fit heap allocator.
// No dependencies; used by every module of the block.
package ffa_pkg;

  localparam int unsigned MAX_BLOCKS = 64;
  localparam int unsigned IDX_W      = $clog2(MAX_BLOCKS);
  localparam int unsigned CNT_W      = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [31:0] HEAP_BASE_RST = 32'd4096;
  localparam logic [31:0] HEAP_SIZE_RST = 32'd4096;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEAP_BASE = 2'd0,
    REG_HEAP_SIZE = 2'd1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_RESET = 2'd2,
    OP_RSVD  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_ARG   = 3'd1,
    ST_NO_FIT    = 3'd2,
    ST_FULL      = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] req_size;
    logic [31:0] req_alignment;
    logic [31:0] free_address;
  } req_t;

  typedef struct packed {
    logic [31:0] result_address;
    logic [2:0]  status;
  } rsp_t;

  typedef struct packed {
    logic [31:0] addr;
    logic [31:0] size;
    logic        free;
  } entry_t;

  localparam entry_t ENTRY_RST = '{addr: HEAP_BASE_RST, size: HEAP_SIZE_RST, free: 1'b1};

  // Chain control broadcast to every cell
  typedef struct packed {
    logic             shift;
    logic             push;
    logic [IDX_W-1:0] wr_idx;
    entry_t           wr_data;
  } chain_ctrl_t;

endpackage

FILE: rtl/core/ffa_cell.sv
// One table cell: holds a heap block, shifts toward the head of the chain.
// Depends on ffa_pkg.
module ffa_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [ffa_pkg::IDX_W-1:0] cell_idx_i,
  input  ffa_pkg::chain_ctrl_t      chain_i,
  input  ffa_pkg::entry_t           right_i,
  output ffa_pkg::entry_t           entry_o
);
  import ffa_pkg::*;

  entry_t entry_q, entry_d;

  always_comb begin
    entry_d = entry_q;
    if (chain_i.push && (chain_i.wr_idx == cell_idx_i)) begin
      entry_d = chain_i.wr_data;
    end else if (chain_i.shift) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= ENTRY_RST;
    end else begin
      entry_q <= entry_d;
    end
  end

  assign entry_o = entry_q;

endmodule

FILE: rtl/core/ffa_ctrl.sv
// Sequencer of the allocator: rotates the cell chain once per allocate or free,
// splitting or merging blocks as they pass the head. Depends on ffa_pkg.
module ffa_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  ffa_pkg::req_t                 in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output ffa_pkg::rsp_t                 out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ffa_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]                   cfg_data_i,
  input  ffa_pkg::entry_t               head_i,
  output ffa_pkg::chain_ctrl_t          chain_o
);
  import ffa_pkg::*;
  `include "first_fit_aligned_heap_allocator_defines.svh"

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CHECK = 6'b000010,
    S_SCAN  = 6'b000100,
    S_SPLIT = 6'b001000,
    S_FLUSH = 6'b010000,
    S_DONE  = 6'b100000
  } state_e;

  state_e          state_q, state_d;
  req_t            req_q;
  logic [31:0]     base_q, size_q;
  logic [31:0]     amask_q, amask_d;
  logic [CNT_W-1:0] occ_q, occ_d, rem_q, rem_d;
  logic            hit_q, hit_d;
  entry_t          pend_q, pend_d;
  logic            pend_v_q, pend_v_d, pend_fr_q, pend_fr_d;
  entry_t          sp1_q, sp1_d, sp2_q, sp2_d;
  logic [1:0]      sp_n_q, sp_n_d;
  logic [31:0]     res_addr_q, res_addr_d;
  status_e         res_st_q, res_st_d;
  logic            out_valid_q, out_valid_d;
  rsp_t            out_data_q, out_data_d;
  chain_ctrl_t     chain;

  // Per-entry fit check for allocate
  logic [32:0] start33, aligned33, blk_end33, base_end33;
  logic [33:0] alloc_end34;
  logic [31:0] head_sz, tail_sz;
  logic        fits, has_head, has_tail;
  logic [1:0]  extra;
  logic [CNT_W:0] need;
  entry_t      head_pc, alloc_pc, tail_pc;
  logic        adj_pend;

  assign start33     = {1'b0, head_i.addr};
  assign aligned33   = (start33 + {1'b0, amask_q}) & ~{1'b0, amask_q};
  assign blk_end33   = start33 + {1'b0, head_i.size};
  assign alloc_end34 = {1'b0, aligned33} + {2'b00, req_q.req_size};
  assign fits        = head_i.free && !aligned33[32] && (alloc_end34 <= {1'b0, blk_end33});
  assign head_sz     = aligned33[31:0] - head_i.addr;
  assign tail_sz     = blk_end33[31:0] - alloc_end34[31:0];
  assign has_head    = (head_sz != 32'd0);
  assign has_tail    = (tail_sz != 32'd0);
  assign extra       = {1'b0, has_head} + {1'b0, has_tail};
  assign need        = {1'b0, occ_q} + {{(CNT_W-1){1'b0}}, extra};
  assign head_pc     = '{addr: head_i.addr, size: head_sz, free: 1'b1};
  assign alloc_pc    = '{addr: aligned33[31:0], size: req_q.req_size, free: 1'b0};
  assign tail_pc     = '{addr: alloc_end34[31:0], size: tail_sz, free: 1'b1};
  assign adj_pend    = ({1'b0, pend_q.addr} + {1'b0, pend_q.size}) == start33;
  assign base_end33  = {1'b0, base_q} + {1'b0, size_q};

  always_comb begin
    state_d     = state_q;
    amask_d     = amask_q;
    occ_d       = occ_q;
    rem_d       = rem_q;
    hit_d       = hit_q;
    pend_d      = pend_q;
    pend_v_d    = pend_v_q;
    pend_fr_d   = pend_fr_q;
    sp1_d       = sp1_q;
    sp2_d       = sp2_q;
    sp_n_d      = sp_n_q;
    res_addr_d  = res_addr_q;
    res_st_d    = res_st_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    chain       = '{shift: 1'b0, push: 1'b0, wr_idx: '0, wr_data: head_i};

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_CHECK;
      end
      S_CHECK: begin
        res_addr_d = 32'd0;
        hit_d      = 1'b0;
        pend_v_d   = 1'b0;
        pend_fr_d  = 1'b0;
        rem_d      = occ_q;
        amask_d    = req_q.req_alignment - 32'd1;
        state_d    = S_DONE;
        unique case (op_e'(req_q.op))
          OP_ALLOC: begin
            if (req_q.req_size == 32'd0 || req_q.req_alignment == 32'd0 ||
                (req_q.req_alignment & (req_q.req_alignment - 32'd1)) != 32'd0) begin
              res_st_d = ST_BAD_ARG;
            end else begin
              res_st_d = ST_NO_FIT;
              state_d  = S_SCAN;
            end
          end
          OP_FREE: begin
            if (req_q.free_address == 32'd0) begin
              res_st_d = ST_BAD_ARG;
            end else begin
              res_st_d = ST_NOT_FOUND;
              state_d  = S_SCAN;
            end
          end
          OP_RESET: begin
            if (base_q == 32'd0 || size_q == 32'd0 || base_end33 > 33'h1_0000_0000) begin
              res_st_d = ST_BAD_ARG;
            end else begin
              // rebuild as a single free block in cell 0
              res_st_d = ST_OK;
              chain    = '{shift: 1'b0, push: 1'b1, wr_idx: '0,
                           wr_data: '{addr: base_q, size: size_q, free: 1'b1}};
              occ_d    = CNT_W'(1);
            end
          end
          default: res_st_d = ST_BAD_ARG;
        endcase
      end
      S_SCAN: begin
        chain.shift = 1'b1;
        rem_d       = rem_q - CNT_W'(1);
        occ_d       = occ_q - CNT_W'(1);
        if (op_e'(req_q.op) == OP_ALLOC) begin
          chain.push   = 1'b1;
          chain.wr_idx = IDX_W'(occ_q - CNT_W'(1));
          occ_d        = occ_q;
          if (!hit_q && fits) begin
            hit_d = 1'b1;
            if (need > (CNT_W+1)'(MAX_BLOCKS)) begin
              res_st_d = ST_FULL;
            end else begin
              res_st_d   = ST_OK;
              res_addr_d = aligned33[31:0];
              sp_n_d     = extra;
              if (has_head) begin
                chain.wr_data = head_pc;
                sp1_d         = alloc_pc;
                sp2_d         = tail_pc;
              end else begin
                chain.wr_data = alloc_pc;
                sp1_d         = tail_pc;
              end
            end
          end
          if (!hit_q && fits && need <= (CNT_W+1)'(MAX_BLOCKS) && extra != 2'd0) begin
            state_d = S_SPLIT;
          end else if (rem_d == '0) begin
            state_d = S_DONE;
          end
        end else begin
          // free: one entry waits in pend so it can absorb its successor
          if (!hit_q && !head_i.free && head_i.addr == req_q.free_address) begin
            hit_d     = 1'b1;
            res_st_d  = ST_OK;
            pend_fr_d = 1'b1;
            if (pend_v_q && pend_q.free && adj_pend) begin
              pend_d.size = pend_q.size + head_i.size;
            end else begin
              chain.push    = pend_v_q;
              chain.wr_data = pend_q;
              pend_d        = '{addr: head_i.addr, size: head_i.size, free: 1'b1};
              pend_v_d      = 1'b1;
            end
          end else if (pend_fr_q && head_i.free && adj_pend) begin
            pend_d.size = pend_q.size + head_i.size;
            pend_fr_d   = 1'b0;
          end else begin
            chain.push    = pend_v_q;
            chain.wr_data = pend_q;
            pend_d        = head_i;
            pend_v_d      = 1'b1;
            pend_fr_d     = 1'b0;
          end
          chain.wr_idx = IDX_W'(occ_q - CNT_W'(1));
          if (chain.push) occ_d = occ_q;
          if (rem_d == '0) state_d = S_FLUSH;
        end
      end
      S_SPLIT: begin
        chain.push    = 1'b1;
        chain.wr_idx  = IDX_W'(occ_q);
        chain.wr_data = sp1_q;
        occ_d         = occ_q + CNT_W'(1);
        sp1_d         = sp2_q;
        sp_n_d        = sp_n_q - 2'd1;
        if (sp_n_q == 2'd1) state_d = (rem_q == '0) ? S_DONE : S_SCAN;
      end
      S_FLUSH: begin
        chain.push    = pend_v_q;
        chain.wr_idx  = IDX_W'(occ_q);
        chain.wr_data = pend_q;
        if (pend_v_q) occ_d = occ_q + CNT_W'(1);
        pend_v_d = 1'b0;
        state_d  = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_data_d  = '{result_address: res_addr_q, status: res_st_q};
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      base_q      <= HEAP_BASE_RST;
      size_q      <= HEAP_SIZE_RST;
      occ_q       <= CNT_W'(1);
      rem_q       <= '0;
      hit_q       <= 1'b0;
      pend_v_q    <= 1'b0;
      pend_fr_q   <= 1'b0;
      sp_n_q      <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      occ_q       <= occ_d;
      rem_q       <= rem_d;
      hit_q       <= hit_d;
      pend_v_q    <= pend_v_d;
      pend_fr_q   <= pend_fr_d;
      sp_n_q      <= sp_n_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_index_i == REG_HEAP_BASE) base_q <= cfg_data_i;
      if (cfg_valid_i && cfg_index_i == REG_HEAP_SIZE) size_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) req_q <= in_data_i;
    amask_q    <= amask_d;
    pend_q     <= pend_d;
    sp1_q      <= sp1_d;
    sp2_q      <= sp2_d;
    res_addr_q <= res_addr_d;
    res_st_q   <= res_st_d;
    out_data_q <= out_data_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign cfg_ready_o = 1'b1;
  assign chain_o     = chain;

  `FFA_ASSERT_IMP(a_occ_bound, 1'b1, occ_q <= CNT_W'(MAX_BLOCKS), "chain occupancy overflow")
  `FFA_ASSERT_IMP(a_idle_nonempty, state_q == S_IDLE, occ_q != '0, "table empty while idle")
  `FFA_ASSERT_IMP(a_push_room, chain.push && !chain.shift && state_q != S_CHECK,
                  occ_q < CNT_W'(MAX_BLOCKS), "push into full chain")
  `FFA_ASSERT_NXT(a_accept_check, in_valid_i && !in_stall_o, state_q == S_CHECK,
                  "accepted transaction not checked")

endmodule

FILE: rtl/core/first_fit_aligned_heap_allocator.sv
// Top level of the first-fit aligned heap allocator: sequencer plus cell chain.
// Depends on ffa_pkg, ffa_ctrl and ffa_cell.
//
//  channel  dir  handshake            payload
//  in       in   in_valid_i/in_stall_o   ffa_pkg::req_t
//  out      out  out_valid_o/out_stall_i ffa_pkg::rsp_t
//  cfg      in   cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// An allocate passes the check, one scan step per table block, a split step per
// piece that it splits off (up to two) and done; a free passes the check, the
// scan, a flush step and done. The chain rotates one cell per scan step.
// A table reset, an unused op or an argument error goes from the check to done.
// The next transaction is taken in the cycle after the result is written.
// After reset the table holds one free block of 4096 bytes at 4096.
// A finished result waits in the output register while out_stall_i is high.
module first_fit_aligned_heap_allocator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  ffa_pkg::req_t                 in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output ffa_pkg::rsp_t                 out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ffa_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]                   cfg_data_i
);
  import ffa_pkg::*;

  chain_ctrl_t chain;
  entry_t      cells [MAX_BLOCKS];
  entry_t      right [MAX_BLOCKS];

  ffa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .head_i      (cells[0]),
    .chain_o     (chain)
  );

  for (genvar k = 0; k < MAX_BLOCKS; k++) begin : g_cell
    if (k == MAX_BLOCKS - 1) begin : g_last
      assign right[k] = '0;
    end else begin : g_mid
      assign right[k] = cells[k+1];
    end
    ffa_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (IDX_W'(k)),
      .chain_i    (chain),
      .right_i    (right[k]),
      .entry_o    (cells[k])
    );
  end

endmodule
